// File: hw/rtl/qsed_pkg.sv
`default_nettype none

package qsed_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_X         = 8'h78;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_BAD_QUOTE = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_closing;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        t_status    status;
    } t_out_item;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        hex_val = v[3:0];
    endfunction

    function automatic t_out_item byte_item(input logic [7:0] b);
        t_out_item it;
        it.out_byte      = b;
        it.byte_valid    = 1'b1;
        it.end_of_string = 1'b0;
        it.status        = ST_OK;
        byte_item = it;
    endfunction

    function automatic t_out_item end_item(input t_status st);
        t_out_item it;
        it.out_byte      = 8'h00;
        it.byte_valid    = 1'b0;
        it.end_of_string = 1'b1;
        it.status        = st;
        end_item = it;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/quoted_string_escape_decoder.sv
`default_nettype none

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_ready | i_in  (in_char, is_closing)
// out      | output    | o_out_valid/i_out_ready | o_out (out_byte, byte_valid,
//          |           |                         |        end_of_string, status)
//
// one request per cycle while the result queue has room; a taken request is held in r_in and
// its results go through the result queue to o_out; a request that yields two results holds
// the decode stage only while the two-entry result queue cannot take both at once
// reset (synchronous, active low) empties both stages and waits for an opening quote
// a stall on out fills the result queue, then the decode register, then drops o_in_ready

module quoted_string_escape_decoder
    import qsed_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire t_in_item i_in,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out
);

    logic              r_in_valid;
    t_in_item          r_in;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_open_quote, n_open_quote;
    logic              r_quote_ok, n_quote_ok;
    logic [7:0]        r_first_hex, n_first_hex;
    t_out_item         r_q [QUEUE_DEPTH];
    t_out_item         n_q [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    logic              en_a, en_b;
    logic [7:0]        byte_a;
    t_out_item         item_b;
    t_out_item         res0, res1;
    logic [QCNT_W-1:0] res_n;
    logic              pop, advance;
    logic [QCNT_W-1:0] base, free_slots;

    // decode of the held character
    always_comb begin
        logic [7:0] c;
        logic       cl;
        t_status    fin_st;
        c            = r_in.in_char;
        cl           = r_in.is_closing;
        fin_st       = (r_quote_ok && c == r_open_quote) ? ST_OK : ST_BAD_QUOTE;
        n_phase      = r_phase;
        n_open_quote = r_open_quote;
        n_quote_ok   = r_quote_ok;
        n_first_hex  = r_first_hex;
        en_a         = 1'b0;
        byte_a       = c;
        en_b         = 1'b0;
        item_b       = byte_item(c);
        unique case (r_phase)
            PH_BODY: begin
                if (cl) begin
                    en_b    = 1'b1;
                    item_b  = end_item(fin_st);
                    n_phase = PH_IDLE;
                end else if (c == CH_BACKSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    en_b    = r_quote_ok;
                    n_phase = PH_BODY;
                end
            end
            PH_ESC: begin
                if (cl) begin
                    en_a    = r_quote_ok;
                    byte_a  = CH_BACKSLASH;
                    en_b    = 1'b1;
                    item_b  = end_item(fin_st);
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_BODY;
                    en_b    = r_quote_ok;
                    case (c)
                        CH_N:    item_b = byte_item(CH_LF);
                        CH_R:    item_b = byte_item(CH_CR);
                        CH_T:    item_b = byte_item(CH_TAB);
                        CH_X: begin
                            en_b    = 1'b0;
                            n_phase = PH_HEX1;
                        end
                        default: item_b = byte_item(c);
                    endcase
                end
            end
            PH_HEX1: begin
                if (cl) begin
                    en_b    = 1'b1;
                    item_b  = end_item(fin_st);
                    n_phase = PH_IDLE;
                end else if (hex_ok(c)) begin
                    n_first_hex = c;
                    n_phase     = PH_HEX2;
                end else if (c == CH_BACKSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    en_b    = r_quote_ok;
                    n_phase = PH_BODY;
                end
            end
            PH_HEX2: begin
                if (cl) begin
                    en_a    = r_quote_ok;
                    byte_a  = r_first_hex;
                    en_b    = 1'b1;
                    item_b  = end_item(fin_st);
                    n_phase = PH_IDLE;
                end else if (hex_ok(c)) begin
                    en_b    = r_quote_ok;
                    item_b  = byte_item({hex_val(r_first_hex), hex_val(c)});
                    n_phase = PH_BODY;
                end else begin
                    // lone hex digit goes out, then the character is decoded as body
                    en_a   = r_quote_ok;
                    byte_a = r_first_hex;
                    if (c == CH_BACKSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        en_b    = r_quote_ok;
                        n_phase = PH_BODY;
                    end
                end
            end
            default: begin
                if (cl) begin
                    en_b    = 1'b1;
                    item_b  = end_item(ST_TOO_SHORT);
                    n_phase = PH_IDLE;
                end else begin
                    n_open_quote = c;
                    n_quote_ok   = (c == CH_DQUOTE) || (c == CH_SQUOTE);
                    n_phase      = PH_BODY;
                end
            end
        endcase
    end

    // pack the results to the front
    always_comb begin
        if (en_a) begin
            res0  = byte_item(byte_a);
            res1  = item_b;
            res_n = en_b ? QCNT_W'(2) : QCNT_W'(1);
        end else begin
            res0  = item_b;
            res1  = item_b;
            res_n = en_b ? QCNT_W'(1) : QCNT_W'(0);
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out       = r_q[0];
    assign pop         = o_out_valid && i_out_ready;
    assign base        = r_cnt - QCNT_W'(pop);
    assign free_slots  = QCNT_W'(QUEUE_DEPTH) - base;
    assign advance     = r_in_valid && (free_slots >= res_n);
    assign o_in_ready  = !r_in_valid || advance;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        n_cnt = base;
        if (advance) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (QCNT_W'(i) == base && res_n != '0) begin
                    n_q[i] = res0;
                end
                if (QCNT_W'(i) == base + QCNT_W'(1) && res_n == QCNT_W'(2)) begin
                    n_q[i] = res1;
                end
            end
            n_cnt = base + res_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= PH_IDLE;
            r_open_quote <= 8'h00;
            r_quote_ok   <= 1'b0;
            r_first_hex  <= 8'h00;
            r_cnt        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_phase      <= n_phase;
                r_open_quote <= n_open_quote;
                r_quote_ok   <= n_quote_ok;
                r_first_hex  <= n_first_hex;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_closing_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.is_closing |=> r_phase == PH_IDLE)
        else $error("closing character did not return to idle");

    a_closing_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.is_closing |-> res_n != '0 && (res_n == QCNT_W'(2) ?
            res1.end_of_string : res0.end_of_string))
        else $error("closing character gave no end result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held character lost while stalled");

endmodule

`default_nettype wire
